@@ hw/rtl/hdd_pkg.sv @@
// ----------------------------------------------------------------------------
// hdd_pkg
// Shared types and constants of the halfword dictionary decoder.
// ----------------------------------------------------------------------------
package hdd_pkg;

    localparam int SIZE_BYTES   = 4;
    localparam int INDEX_BITS   = 6;
    localparam int LITERAL_BITS = 16;
    localparam int STORE_BITS   = 16;
    localparam int FIFO_DEPTH   = 4;

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_TABLE,
        PH_BITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic        ok;
        logic        lit;
        logic [4:0]  need;
        logic [15:0] bits;
    } sym_t;

    typedef struct packed {
        logic [LITERAL_BITS-1:0] halfword;
        logic                    field_last;
        logic                    run_last;
    } result_t;

    typedef struct packed {
        logic                    lit;
        logic                    zero;
        logic                    field_last;
        logic [LITERAL_BITS-1:0] bits;
    } slot_t;

endpackage

@@ hw/rtl/hdd_ram.sv @@
// ----------------------------------------------------------------------------
// hdd_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module hdd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/halfword_dictionary_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// halfword_dictionary_decoder_unit
// Expands a byte-wise compressed field (size header, halfword table, bit
// stream of literal and table-index symbols) into 16-bit halfwords.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_byte, field_start
// out      output     out_valid / out_ready out_halfword, field_last, run_last
//
// A request is decoded in the cycle it is accepted; table reads are
// registered in two copies of the table RAM, and the halfwords then enter a
// four-entry result queue. A byte yields up to two halfwords and the queue
// drains one per cycle while out_ready is high, so the rate is one byte per
// cycle in the header and table while the queue has room, and lower when
// each byte completes two symbols. Input stalls only when the queue cannot
// take two more halfwords. Reset clears the control state at once; the table
// holds whatever the last field loaded.
// ----------------------------------------------------------------------------
module halfword_dictionary_decoder_unit #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        field_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_halfword,
    output logic        field_last,
    output logic        run_last
);

    import hdd_pkg::*;

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int HC_W  = $clog2(2 * TABLE_ENTRIES);
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    function automatic sym_t decode_sym(input logic [23:0] s, input logic [4:0] fill);
        sym_t        r;
        logic [23:0] sh;
        r  = '0;
        sh = '0;
        if (fill != 5'd0)
        begin
            r.lit  = s[fill - 5'd1];
            r.need = r.lit ? 5'(LITERAL_BITS + 1) : 5'(INDEX_BITS + 1);
            if (fill >= r.need)
            begin
                r.ok = 1'b1;
                sh   = s >> (fill - r.need);
            end
            r.bits = sh[15:0];
        end
        return r;
    endfunction

    phase_t          phase_reg, phase_next;
    logic [HC_W-1:0] hc_reg, hc_next;
    logic [31:0]     rem_reg, rem_next;
    logic [7:0]      hold_reg, hold_next;
    logic [15:0]     store_reg, store_next;
    logic [4:0]      fill_reg, fill_next;

    phase_t          phase_cur;
    logic [HC_W-1:0] hc_cur;
    logic [31:0]     rem_cur, rem_mid;
    logic [15:0]     store_cur;
    logic [4:0]      fill_cur, f0, f1;
    logic [23:0]     s;
    sym_t            sym0, sym1;
    logic [1:0]      n;
    slot_t           slot0, slot1;

    logic            accept;
    logic            tbl_we;
    logic [AW-1:0]   tbl_waddr;
    logic [15:0]     tbl_wdata;
    logic [AW-1:0]   raddr0, raddr1;
    logic [15:0]     rdata0, rdata1;

    logic [1:0]      s1_n_reg;
    slot_t           s1_slot0_reg, s1_slot1_reg;

    result_t         fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic            pop;
    result_t         push0, push1;
    result_t         head;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        phase_cur  = field_start ? PH_SIZE : phase_reg;
        hc_cur     = field_start ? '0 : hc_reg;
        rem_cur    = field_start ? '0 : rem_reg;
        store_cur  = field_start ? '0 : store_reg;
        fill_cur   = field_start ? '0 : fill_reg;

        phase_next = phase_cur;
        hc_next    = hc_cur;
        rem_next   = rem_cur;
        hold_next  = hold_reg;
        store_next = store_cur;
        fill_next  = fill_cur;
        tbl_we     = 1'b0;
        tbl_waddr  = hc_cur[HC_W-1:1];
        tbl_wdata  = {hold_reg, in_byte};
        s          = {store_cur, in_byte};
        f0         = fill_cur + 5'd8;
        f1         = f0;
        rem_mid    = rem_cur;
        sym0       = decode_sym(s, f0);
        sym1       = '0;
        n          = 2'd0;
        slot0      = '0;
        slot1      = '0;

        unique case (phase_cur)
            PH_SIZE:
            begin
                rem_next = {rem_cur[23:0], in_byte};
                if (hc_cur == HC_W'(SIZE_BYTES - 1))
                begin
                    hc_next    = '0;
                    phase_next = PH_TABLE;
                end
                else
                begin
                    hc_next = hc_cur + 1'b1;
                end
            end
            PH_TABLE:
            begin
                if (!hc_cur[0])
                begin
                    hold_next = in_byte;
                end
                else
                begin
                    tbl_we = accept;
                end
                if (hc_cur == HC_W'(2 * TABLE_ENTRIES - 1))
                begin
                    hc_next    = '0;
                    phase_next = (rem_cur == 32'd0) ? PH_DONE : PH_BITS;
                end
                else
                begin
                    hc_next = hc_cur + 1'b1;
                end
            end
            PH_BITS:
            begin
                if (rem_cur != 32'd0 && sym0.ok)
                begin
                    n                = 2'd1;
                    f1               = f0 - sym0.need;
                    slot0.lit        = sym0.lit;
                    slot0.bits       = sym0.bits;
                    slot0.zero       = !sym0.lit &&
                                       (32'(sym0.bits[INDEX_BITS-1:0]) >= TABLE_ENTRIES);
                    slot0.field_last = (rem_cur <= 32'd2);
                    rem_mid          = slot0.field_last ? 32'd0 : rem_cur - 32'd2;
                end
                sym1 = decode_sym(s, f1);
                fill_next = f1;
                rem_next  = rem_mid;
                if (n == 2'd1 && rem_mid != 32'd0 && sym1.ok)
                begin
                    n                = 2'd2;
                    fill_next        = f1 - sym1.need;
                    slot1.lit        = sym1.lit;
                    slot1.bits       = sym1.bits;
                    slot1.zero       = !sym1.lit &&
                                       (32'(sym1.bits[INDEX_BITS-1:0]) >= TABLE_ENTRIES);
                    slot1.field_last = (rem_mid <= 32'd2);
                    rem_next         = slot1.field_last ? 32'd0 : rem_mid - 32'd2;
                end
                store_next = s[15:0];
                if (rem_next == 32'd0)
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_SIZE;
            end
        endcase
    end

    assign raddr0 = AW'(32'(slot0.bits[INDEX_BITS-1:0]));
    assign raddr1 = AW'(32'(slot1.bits[INDEX_BITS-1:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIZE;
            hc_reg    <= '0;
            rem_reg   <= '0;
            hold_reg  <= '0;
            store_reg <= '0;
            fill_reg  <= '0;
            s1_n_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                hc_reg    <= hc_next;
                rem_reg   <= rem_next;
                hold_reg  <= hold_next;
                store_reg <= store_next;
                fill_reg  <= fill_next;
            end
            s1_n_reg <= accept ? n : 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_slot0_reg <= slot0;
            s1_slot1_reg <= slot1;
        end
    end

    hdd_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram0 (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (accept),
        .raddr (raddr0),
        .rdata (rdata0)
    );

    hdd_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram1 (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (accept),
        .raddr (raddr1),
        .rdata (rdata1)
    );

    always_comb
    begin
        push0.halfword   = s1_slot0_reg.lit ? s1_slot0_reg.bits :
                           (s1_slot0_reg.zero ? 16'd0 : rdata0);
        push0.field_last = s1_slot0_reg.field_last;
        push0.run_last   = (s1_n_reg == 2'd1);
        push1.halfword   = s1_slot1_reg.lit ? s1_slot1_reg.bits :
                           (s1_slot1_reg.zero ? 16'd0 : rdata1);
        push1.field_last = s1_slot1_reg.field_last;
        push1.run_last   = 1'b1;
    end

    assign head         = fifo_reg[rd_ptr_reg];
    assign out_valid    = (cnt_reg != '0);
    assign out_halfword = head.halfword;
    assign field_last   = head.field_last;
    assign run_last     = head.run_last;
    assign pop          = out_valid && out_ready;
    assign in_ready     = ((cnt_reg + CNT_W'(s1_n_reg)) <= CNT_W'(FIFO_DEPTH - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(s1_n_reg);
            cnt_reg    <= cnt_reg + CNT_W'(s1_n_reg) - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_n_reg != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= push0;
        end
        if (s1_n_reg == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + 1'b1] <= push1;
        end
    end

endmodule

@@ hw/rtl/hdd_checker.sv @@
// ----------------------------------------------------------------------------
// hdd_checker
// Port-level checks of the halfword dictionary decoder.
// ----------------------------------------------------------------------------
module hdd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  in_byte,
    input logic        field_start,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_halfword,
    input logic        field_last,
    input logic        run_last
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_halfword) && $stable(field_last) && $stable(run_last))
        else $error("result changed while stalled");

    // The final halfword of a field is always the last one from its byte.
    a_last_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_last |-> run_last)
        else $error("field_last without run_last");

    // A result appearing on an empty output comes from an accepted byte, through the slot registers and the queue.
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching request");

    // A waiting request keeps its payload.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=>
            in_valid && $stable(in_byte) && $stable(field_start))
        else $error("request changed while waiting");

endmodule

bind halfword_dictionary_decoder_unit hdd_checker u_hdd_checker (.*);
